### hw/rtl/otrb_pkg.sv
// ----------------------------------------------------------------------------
// Trace ring buffer package
// Types and constants shared by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package otrb_pkg;

  // Number of entries held in the ring. The write position wraps at this value.
  localparam int unsigned CAPACITY      = 32;
  localparam int unsigned IDX_W         = $clog2(CAPACITY);
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1);
  // Longest payload length that is stored; longer lengths are clipped to it.
  localparam int unsigned PAYLOAD_BYTES = 255;
  localparam logic [31:0] LOW31_MASK    = 32'h7FFF_FFFF;

  // Command queue between the front end and the back end.
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  // Stream widths.
  localparam int unsigned S_TDATA_W     = 176;
  localparam int unsigned M_TDATA_W     = 160;

  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_READ_ALL   = 2'd2,
    OP_READ_RANGE = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] stamp;
    logic [7:0]  kind;
    logic [7:0]  length;
    logic [63:0] payload;
    logic [31:0] range_lo;
    logic [31:0] range_hi;
  } cmd_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  kind;
    logic [7:0]  length;
    logic [63:0] payload;
  } entry_t;

endpackage

### hw/rtl/otrb_front.sv
// ----------------------------------------------------------------------------
// Trace ring buffer front end
// Takes input beats, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module otrb_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [otrb_pkg::S_TDATA_W-1:0]     s_tdata_i,
  input  logic [1:0]                         s_tuser_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output otrb_pkg::cmd_t                     cmd_o
);

  otrb_pkg::cmd_t                  cmd_in;
  otrb_pkg::cmd_t                  queue_q [otrb_pkg::QUEUE_DEPTH];
  logic [otrb_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [otrb_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [otrb_pkg::QPTR_W:0]       fill_q, fill_d;
  logic                            enq, deq;
  logic [7:0]                      len_in;

  // Decode the beat; a length above the stored maximum is clipped.
  always_comb begin
    len_in          = s_tdata_i[47:40];
    cmd_in.op       = otrb_pkg::op_e'(s_tuser_i);
    cmd_in.stamp    = s_tdata_i[31:0];
    cmd_in.kind     = s_tdata_i[39:32];
    cmd_in.length   = ({24'd0, len_in} > otrb_pkg::PAYLOAD_BYTES) ?
                      8'(otrb_pkg::PAYLOAD_BYTES) : len_in;
    cmd_in.payload  = s_tdata_i[111:48];
    cmd_in.range_lo = s_tdata_i[143:112];
    cmd_in.range_hi = s_tdata_i[175:144];
  end

  assign s_tready_o  = (fill_q != (otrb_pkg::QPTR_W + 1)'(otrb_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign enq         = s_tvalid_i && s_tready_o;
  assign deq         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (enq && !deq) begin
      fill_d = fill_q + 1'b1;
    end else if (deq && !enq) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### hw/rtl/otrb_back.sv
// ----------------------------------------------------------------------------
// Trace ring buffer back end
// Holds the entry store, carries out queued commands and drives the result beats.
// ----------------------------------------------------------------------------
module otrb_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [63:0]                        cfg_wdata_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  otrb_pkg::cmd_t                     cmd_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [otrb_pkg::M_TDATA_W-1:0]     m_tdata_o,
  output logic                               m_tuser_o,
  output logic                               m_tlast_o
);

  localparam int unsigned IW = otrb_pkg::IDX_W;
  localparam int unsigned CW = otrb_pkg::CNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic          is_entry;
    logic [31:0]   raw_stamp;
    logic [31:0]   rel_stamp;
    logic [7:0]    kind;
    logic [7:0]    length;
    logic [63:0]   payload;
    logic [CW-1:0] matched;
    logic [CW-1:0] held;
    logic          last;
  } res_t;

  otrb_pkg::entry_t mem [otrb_pkg::CAPACITY];
  otrb_pkg::entry_t rd_q;
  otrb_pkg::entry_t wr_entry;

  state_e         state_q, state_d;
  logic [IW-1:0]  wpos_q, wpos_d;
  logic [CW-1:0]  total_q, total_d;
  logic [63:0]    rs_q, rs_d;
  otrb_pkg::op_e  walk_op_q, walk_op_d;
  logic [31:0]    lo_q, lo_d;
  logic [31:0]    hi_q, hi_d;
  logic [IW-1:0]  walk_idx_q, walk_idx_d;
  logic [CW-1:0]  left_q, left_d;
  logic [CW-1:0]  matched_q, matched_d;
  logic           rd_vld_q, rd_vld_d;
  logic           out_vld_q, out_vld_d;
  res_t           out_q, out_d;

  logic           slot_free, take, adv, issue, emit_entry, walk_end;
  logic           take_cmd, mem_we, full, rs_pos;
  logic [CW-1:0]  total_inc;
  logic [IW-1:0]  wpos_inc, walk_idx_inc;
  logic [31:0]    rel_stamp;
  res_t           done_rec;

  assign slot_free = !out_vld_q || m_tready_i;
  assign full      = (total_q == CW'(otrb_pkg::CAPACITY));
  assign total_inc = full ? total_q : total_q + 1'b1;
  assign wpos_inc  = (wpos_q == IW'(otrb_pkg::CAPACITY - 1)) ? '0 : wpos_q + 1'b1;
  assign walk_idx_inc = (walk_idx_q == IW'(otrb_pkg::CAPACITY - 1)) ? '0 :
                        walk_idx_q + 1'b1;

  // Read all keeps non-empty entries; read range compares the signed stamp.
  assign take = (walk_op_q == otrb_pkg::OP_READ_ALL) ? (rd_q.length != 8'd0) :
                (($signed(rd_q.stamp) >= $signed(lo_q)) &&
                 ($signed(rd_q.stamp) <= $signed(hi_q)));

  // The read register moves on unless it holds a wanted entry with no slot free.
  assign adv        = !rd_vld_q || !take || slot_free;
  assign issue      = (state_q == ST_WALK) && (left_q != '0) && adv;
  assign emit_entry = (state_q == ST_WALK) && rd_vld_q && take && slot_free;
  assign walk_end   = (state_q == ST_WALK) && (left_q == '0) && !rd_vld_q && slot_free;

  assign cmd_ready_o = (state_q == ST_IDLE) && slot_free;
  assign take_cmd    = cmd_valid_i && cmd_ready_o;
  assign mem_we      = take_cmd && (cmd_i.op == otrb_pkg::OP_PUSH);

  assign rs_pos    = !rs_q[63] && (rs_q != 64'd0);
  assign rel_stamp = rs_pos ? rd_q.stamp - (rs_q[31:0] & otrb_pkg::LOW31_MASK) :
                     rd_q.stamp;

  always_comb begin
    wr_entry.stamp   = cmd_i.stamp;
    wr_entry.kind    = cmd_i.kind;
    wr_entry.length  = cmd_i.length;
    wr_entry.payload = cmd_i.payload;
  end

  always_comb begin
    state_d    = state_q;
    wpos_d     = wpos_q;
    total_d    = total_q;
    rs_d       = cfg_we_i ? cfg_wdata_i : rs_q;
    walk_op_d  = walk_op_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    walk_idx_d = walk_idx_q;
    left_d     = left_q;
    matched_d  = matched_q;
    rd_vld_d   = rd_vld_q;
    out_vld_d  = out_vld_q && !m_tready_i;
    out_d      = out_q;

    done_rec          = '0;
    done_rec.last     = 1'b1;
    done_rec.held     = total_q;
    done_rec.matched  = '0;

    if (adv) begin
      rd_vld_d = issue;
    end

    case (state_q)
      ST_IDLE: begin
        if (take_cmd) begin
          case (cmd_i.op)
            otrb_pkg::OP_PUSH: begin
              wpos_d        = wpos_inc;
              total_d       = total_inc;
              done_rec.held = total_inc;
              out_d         = done_rec;
              out_vld_d     = 1'b1;
            end
            otrb_pkg::OP_CLEAR: begin
              wpos_d        = '0;
              total_d       = '0;
              done_rec.held = '0;
              out_d         = done_rec;
              out_vld_d     = 1'b1;
            end
            default: begin
              // Both reads start at the oldest entry.
              state_d    = ST_WALK;
              walk_op_d  = cmd_i.op;
              lo_d       = cmd_i.range_lo;
              hi_d       = cmd_i.range_hi;
              walk_idx_d = full ? wpos_q : '0;
              left_d     = total_q;
              matched_d  = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (issue) begin
          walk_idx_d = walk_idx_inc;
          left_d     = left_q - 1'b1;
        end
        if (emit_entry) begin
          out_d.is_entry  = 1'b1;
          out_d.raw_stamp = rd_q.stamp;
          out_d.rel_stamp = rel_stamp;
          out_d.kind      = rd_q.kind;
          out_d.length    = rd_q.length;
          out_d.payload   = rd_q.payload;
          out_d.matched   = '0;
          out_d.held      = '0;
          out_d.last      = 1'b0;
          out_vld_d       = 1'b1;
          matched_d       = matched_q + 1'b1;
        end else if (walk_end) begin
          done_rec.matched = matched_q;
          out_d            = done_rec;
          out_vld_d        = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wpos_q     <= '0;
      total_q    <= '0;
      rs_q       <= '0;
      walk_op_q  <= otrb_pkg::OP_READ_ALL;
      lo_q       <= '0;
      hi_q       <= '0;
      walk_idx_q <= '0;
      left_q     <= '0;
      matched_q  <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      wpos_q     <= wpos_d;
      total_q    <= total_d;
      rs_q       <= rs_d;
      walk_op_q  <= walk_op_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      walk_idx_q <= walk_idx_d;
      left_q     <= left_d;
      matched_q  <= matched_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
    end
  end

  // Entry store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wpos_q] <= wr_entry;
    end
    if (issue) begin
      rd_q <= mem[walk_idx_q];
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_q.is_entry;
  assign m_tlast_o  = out_q.last;
  assign m_tdata_o  = {4'd0, out_q.held, out_q.matched, out_q.payload, out_q.length,
                       out_q.kind, out_q.rel_stamp, out_q.raw_stamp};

endmodule

### hw/rtl/overwriting_trace_ring_buffer.sv
// ----------------------------------------------------------------------------
// Overwriting trace ring buffer
// Keeps the newest 32 trace entries and answers push, clear and read commands.
// ----------------------------------------------------------------------------
// Usage: each slave beat is one command, selected by s_axis_tuser_i (push,
// clear, read all, read range). Every command ends with one completion beat
// on the master side with tlast set and tuser low; read commands first send
// one beat per matching entry with tuser high, oldest entry first.
// The user must write recording_start through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this.
// A push or clear passes through the command queue and the result register;
// the back end stays idle, so pushes run at one beat per cycle while tready
// is high. A read holds the back end until its walk ends, as the store has
// a single read port and the walk reads one entry per cycle unless stalled;
// its first entry beat passes the command queue, read and result registers.
// A four-deep command queue keeps accepting beats while a read is walking.
// Reset empties the buffer, clears the queue and sets recording_start to 0.
// When the receiver holds tready low, the result register holds its beat,
// the walk pauses and, once the queue fills, s_axis_tready_o falls.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [63:0]                        cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // stamp[31:0], entry_kind[39:32], payload_length[47:40], payload_word[111:48],
  // range_low[143:112], range_high[175:144]
  input  logic [otrb_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // raw_stamp[31:0], relative_stamp[63:32], out_kind[71:64], out_length[79:72],
  // out_payload[143:80], matched[149:144], held_count[155:150], zero[159:156]
  output logic [otrb_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // is_entry[0]
  output logic                               m_axis_tuser_o,
  // last
  output logic                               m_axis_tlast_o
);

  logic           cmd_valid, cmd_ready;
  otrb_pkg::cmd_t cmd;

  otrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  otrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

`ifndef SYNTH
  // The held count never exceeds the ring size.
  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      ({26'd0, m_axis_tdata_o[155:150]} <= otrb_pkg::CAPACITY))
    else $error("held count above capacity");

  // An entry beat is never the closing beat of a command.
  a_entry_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !m_axis_tlast_o)
    else $error("entry beat marked last");

  // A command cannot report more matches than entries held.
  a_matched_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[149:144] <= m_axis_tdata_o[155:150]))
    else $error("match count above held count");
`endif

endmodule
